### hw/rtl/gemm_ta_pkg.sv
// ----------------------------------------------------------------------------
// gemm_ta_pkg
// Shared codes, control-word layout and the microprogram of the transposed-A
// integer matrix multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package gemm_ta_pkg;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_LOAD_C = 2'd2,
      OP_RUN    = 2'd3
   } opcode_type;

   typedef logic [2:0] csr_addr_type;

   localparam csr_addr_type CSR_ALPHA = 3'd0;
   localparam csr_addr_type CSR_BETA  = 3'd1;
   localparam csr_addr_type CSR_ROWS  = 3'd2;
   localparam csr_addr_type CSR_COLS  = 3'd3;
   localparam csr_addr_type CSR_INNER = 3'd4;

   // microprogram step addresses
   typedef logic [3:0] step_type;

   localparam step_type STEP_IDLE  = 4'd0;
   localparam step_type STEP_START = 4'd1;
   localparam step_type STEP_ELEM  = 4'd2;
   localparam step_type STEP_RDAB  = 4'd3;
   localparam step_type STEP_MUL   = 4'd4;
   localparam step_type STEP_ACC   = 4'd5;
   localparam step_type STEP_ALPHA = 4'd6;
   localparam step_type STEP_BETA  = 4'd7;
   localparam step_type STEP_SUM   = 4'd8;
   localparam step_type STEP_EMIT  = 4'd9;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_RUN,     // wait for a run word
      HOLD_RSP      // wait while the result word is stalled
   } hold_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_EMPTY,   // no rows or no columns
      COND_SKIP,    // product term is zero, no inner loop
      COND_KMORE,   // more inner terms to go
      COND_LAST     // final element of the run
   } cond_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_START,
      DP_ELEM,
      DP_RDAB,
      DP_MUL,
      DP_ACC,
      DP_ALPHA,
      DP_BETA,
      DP_SUM,
      DP_ADV
   } dp_type;

   typedef struct packed {
      logic     req_ready;
      hold_type hold;
      cond_type cond;
      step_type jmp;
      step_type nxt;
      dp_type   dp;
   } ucode_type;

   function automatic ucode_type ucode_rom(step_type step);
      ucode_type cw;
      unique case (step)
         STEP_IDLE:  cw = '{1'b1, HOLD_RUN,  COND_NEVER, STEP_IDLE,  STEP_START, DP_NOP};
         STEP_START: cw = '{1'b0, HOLD_NONE, COND_EMPTY, STEP_IDLE,  STEP_ELEM,  DP_START};
         STEP_ELEM:  cw = '{1'b0, HOLD_NONE, COND_SKIP,  STEP_ALPHA, STEP_RDAB,  DP_ELEM};
         STEP_RDAB:  cw = '{1'b0, HOLD_NONE, COND_NEVER, STEP_IDLE,  STEP_MUL,   DP_RDAB};
         STEP_MUL:   cw = '{1'b0, HOLD_NONE, COND_NEVER, STEP_IDLE,  STEP_ACC,   DP_MUL};
         STEP_ACC:   cw = '{1'b0, HOLD_NONE, COND_KMORE, STEP_RDAB,  STEP_ALPHA, DP_ACC};
         STEP_ALPHA: cw = '{1'b0, HOLD_NONE, COND_NEVER, STEP_IDLE,  STEP_BETA,  DP_ALPHA};
         STEP_BETA:  cw = '{1'b0, HOLD_NONE, COND_NEVER, STEP_IDLE,  STEP_SUM,   DP_BETA};
         STEP_SUM:   cw = '{1'b0, HOLD_NONE, COND_NEVER, STEP_IDLE,  STEP_EMIT,  DP_SUM};
         STEP_EMIT:  cw = '{1'b0, HOLD_RSP,  COND_LAST,  STEP_IDLE,  STEP_ELEM,  DP_ADV};
         default:    cw = '{1'b0, HOLD_NONE, COND_NEVER, STEP_IDLE,  STEP_IDLE,  DP_NOP};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/gemm_ta_if.sv
// ----------------------------------------------------------------------------
// gemm_ta channel interfaces
// Request, response and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gemm_ta_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [2:0]        row_index;
   logic [2:0]        col_index;
   logic signed [31:0] elem_value;

   modport source (output valid, output opcode, output row_index, output col_index,
                   output elem_value, input ready);
   modport sink   (input valid, input opcode, input row_index, input col_index,
                   input elem_value, output ready);
endinterface

interface gemm_ta_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        out_row;
   logic [2:0]        out_col;
   logic signed [31:0] out_value;
   logic              last_flag;

   modport source (output valid, output out_row, output out_col, output out_value,
                   output last_flag, input ready);
   modport sink   (input valid, input out_row, input out_col, input out_value,
                   input last_flag, output ready);
endinterface

interface gemm_ta_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [31:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/gemm_ta_core.sv
// ----------------------------------------------------------------------------
// gemm_transposed_a_int32_core
// C = alpha * transpose(A) * B + beta * C on 32-bit wrapping integers.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  words load one element of A (opcode 0, row = k, col = i), of B
//           (opcode 1, row = k, col = j) or of C (opcode 2), or start a run
//           (opcode 3). Loads are taken one per cycle while idle and give no response.
//   rsp_ch  a run writes the new C back to its store and returns every C
//           element in column-major order; last_flag marks the final word.
//   csr_ch  register writes: 0 alpha, 1 beta, 2 rows, 3 cols, 4 inner length.
//           Always ready; write only while no run is in flight. Sizes keep
//           wdata[3:0]; values above MAX_DIM saturate.
// Sequence: a setup step after the run word, then per C element: element,
//   K inner passes (K = inner length; none if alpha or K is zero), alpha,
//   beta, sum and emit. Reading A and B, multiply and accumulate are three
//   steps; one 32x32 multiplier serves products, alpha and beta scaling.
//   req_ch stays not-ready from the run word until the last element is taken.
// Stall: a stalled response holds the sequencer in its emit step.
// Reset: registers return to alpha 1, beta 0, sizes 8; stores are not
//   cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_transposed_a_int32_core #(
   parameter int MAX_DIM = 8
) (
   input  wire             clock,
   input  wire             reset,
   gemm_ta_req_if.sink     req_ch,
   gemm_ta_rsp_if.source   rsp_ch,
   gemm_ta_csr_if.sink     csr_ch
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW    = $clog2(MAX_DIM + 1);

   // ---------------------------------------------------------------- helpers
   function automatic logic [AW-1:0] addr_of(logic [IW-1:0] r, logic [IW-1:0] c);
      return AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
   endfunction

   function automatic logic [CW-1:0] dim_clamp(logic [3:0] v);
      return (int'(v) > MAX_DIM) ? CW'(MAX_DIM) : CW'(v);
   endfunction

   // ---------------------------------------------------------------- state
   gemm_ta_pkg::step_type pc_ff, pc_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [31:0] alpha_ff, beta_ff;
   logic [3:0]  rows_ff, cols_ff, inner_ff;

   logic [IW-1:0] i_ff, j_ff, k_ff;
   logic [31:0]   acc_ff, prod_ff;
   logic [31:0]   a_q_ff, b_q_ff, c_q_ff;

   logic [2:0]    rsp_row_ff, rsp_col_ff;
   logic [31:0]   rsp_value_ff;
   logic          rsp_last_ff;

   logic [31:0] a_mem [DEPTH];
   logic [31:0] b_mem [DEPTH];
   logic [31:0] c_mem [DEPTH];

   // ---------------------------------------------------------------- sequencer
   gemm_ta_pkg::ucode_type cw;
   logic [CW-1:0] r_dim, n_dim, k_dim;
   logic          req_acc, run_acc, load_acc, load_ok;
   logic          stall, cond_true, dp_en;
   logic          i_more, j_more, k_more;

   assign r_dim = dim_clamp(rows_ff);
   assign n_dim = dim_clamp(cols_ff);
   assign k_dim = dim_clamp(inner_ff);

   assign i_more = ((CW + 1)'(i_ff) + (CW + 1)'(1)) < (CW + 1)'(r_dim);
   assign j_more = ((CW + 1)'(j_ff) + (CW + 1)'(1)) < (CW + 1)'(n_dim);
   assign k_more = ((CW + 1)'(k_ff) + (CW + 1)'(1)) < (CW + 1)'(k_dim);

   assign cw       = gemm_ta_pkg::ucode_rom(pc_ff);
   assign req_acc  = req_ch.valid && req_ch.ready;
   assign run_acc  = req_acc && (req_ch.opcode == gemm_ta_pkg::OP_RUN);
   assign load_ok  = (int'(req_ch.row_index) < MAX_DIM) && (int'(req_ch.col_index) < MAX_DIM);
   assign load_acc = req_acc && (req_ch.opcode != gemm_ta_pkg::OP_RUN) && load_ok;

   always_comb begin
      unique case (cw.hold)
         gemm_ta_pkg::HOLD_NONE: stall = 1'b0;
         gemm_ta_pkg::HOLD_RUN:  stall = !run_acc;
         gemm_ta_pkg::HOLD_RSP:  stall = rsp_valid_ff && !rsp_ch.ready;
         default:                stall = 1'b0;
      endcase
      unique case (cw.cond)
         gemm_ta_pkg::COND_NEVER: cond_true = 1'b0;
         gemm_ta_pkg::COND_EMPTY: cond_true = (r_dim == '0) || (n_dim == '0);
         gemm_ta_pkg::COND_SKIP:  cond_true = (alpha_ff == '0) || (k_dim == '0);
         gemm_ta_pkg::COND_KMORE: cond_true = k_more;
         gemm_ta_pkg::COND_LAST:  cond_true = !i_more && !j_more;
         default:                 cond_true = 1'b0;
      endcase
      dp_en = !stall;
      if (stall) begin
         pc_in = pc_ff;
      end else if (cond_true) begin
         pc_in = cw.jmp;
      end else begin
         pc_in = cw.nxt;
      end
   end

   // ---------------------------------------------------------------- datapath
   logic [31:0] mul_a, mul_b, mul_p, new_val;

   always_comb begin
      unique case (cw.dp)
         gemm_ta_pkg::DP_ALPHA: begin
            mul_a = alpha_ff;
            mul_b = acc_ff;
         end
         gemm_ta_pkg::DP_BETA: begin
            mul_a = beta_ff;
            mul_b = c_q_ff;
         end
         default: begin
            mul_a = a_q_ff;
            mul_b = b_q_ff;
         end
      endcase
   end

   assign mul_p   = 32'(mul_a * mul_b);
   // beta of zero must not pick up the old C
   assign new_val = acc_ff + ((beta_ff != '0) ? prod_ff : 32'd0);

   always_ff @(posedge clock) begin
      if (dp_en) begin
         unique case (cw.dp)
            gemm_ta_pkg::DP_START: begin
               i_ff <= '0;
               j_ff <= '0;
            end
            gemm_ta_pkg::DP_ELEM: begin
               acc_ff <= '0;
               k_ff   <= '0;
            end
            gemm_ta_pkg::DP_MUL: begin
               prod_ff <= mul_p;
            end
            gemm_ta_pkg::DP_ACC: begin
               acc_ff <= acc_ff + prod_ff;
               k_ff   <= k_ff + IW'(1);
            end
            gemm_ta_pkg::DP_ALPHA: begin
               prod_ff <= mul_p;
            end
            gemm_ta_pkg::DP_BETA: begin
               acc_ff  <= prod_ff;
               prod_ff <= mul_p;
            end
            gemm_ta_pkg::DP_SUM: begin
               rsp_row_ff   <= 3'(i_ff);
               rsp_col_ff   <= 3'(j_ff);
               rsp_value_ff <= new_val;
               rsp_last_ff  <= !i_more && !j_more;
            end
            gemm_ta_pkg::DP_ADV: begin
               if (i_more) begin
                  i_ff <= i_ff + IW'(1);
               end else begin
                  i_ff <= '0;
                  j_ff <= j_ff + IW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- stores
   logic [AW-1:0] load_addr;
   logic          rd_ab, rd_c, wb_c;

   assign load_addr = addr_of(IW'(req_ch.row_index), IW'(req_ch.col_index));
   assign rd_ab     = dp_en && (cw.dp == gemm_ta_pkg::DP_RDAB);
   assign rd_c      = dp_en && (cw.dp == gemm_ta_pkg::DP_ELEM);
   assign wb_c      = dp_en && (cw.dp == gemm_ta_pkg::DP_SUM);

   always_ff @(posedge clock) begin
      if (load_acc && (req_ch.opcode == gemm_ta_pkg::OP_LOAD_A)) begin
         a_mem[load_addr] <= req_ch.elem_value;
      end
      if (rd_ab) begin
         a_q_ff <= a_mem[addr_of(k_ff, i_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc && (req_ch.opcode == gemm_ta_pkg::OP_LOAD_B)) begin
         b_mem[load_addr] <= req_ch.elem_value;
      end
      if (rd_ab) begin
         b_q_ff <= b_mem[addr_of(k_ff, j_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (wb_c) begin
         c_mem[addr_of(i_ff, j_ff)] <= new_val;
      end else if (load_acc && (req_ch.opcode == gemm_ta_pkg::OP_LOAD_C)) begin
         c_mem[load_addr] <= req_ch.elem_value;
      end
      if (rd_c) begin
         c_q_ff <= c_mem[addr_of(i_ff, j_ff)];
      end
   end

   // ---------------------------------------------------------------- control regs
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (wb_c) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= gemm_ta_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= 32'd1;
         beta_ff      <= 32'd0;
         rows_ff      <= 4'd8;
         cols_ff      <= 4'd8;
         inner_ff     <= 4'd8;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.addr)
               gemm_ta_pkg::CSR_ALPHA: alpha_ff <= csr_ch.wdata;
               gemm_ta_pkg::CSR_BETA:  beta_ff  <= csr_ch.wdata;
               gemm_ta_pkg::CSR_ROWS:  rows_ff  <= csr_ch.wdata[3:0];
               gemm_ta_pkg::CSR_COLS:  cols_ff  <= csr_ch.wdata[3:0];
               gemm_ta_pkg::CSR_INNER: inner_ff <= csr_ch.wdata[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- ports
   assign req_ch.ready     = cw.req_ready;
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_row   = rsp_row_ff;
   assign rsp_ch.out_col   = rsp_col_ff;
   assign rsp_ch.out_value = rsp_value_ff;
   assign rsp_ch.last_flag = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_rsp_only_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pc_ff == gemm_ta_pkg::STEP_EMIT))
      else $error("response word outside emit step");

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      run_acc |=> (pc_ff == gemm_ta_pkg::STEP_START))
      else $error("run word did not start the sequencer");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_flag) |=>
         (pc_ff == gemm_ta_pkg::STEP_IDLE))
      else $error("sequencer busy after last word");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == gemm_ta_pkg::STEP_SUM) |->
         (((CW + 1)'(i_ff) < (CW + 1)'(r_dim)) && ((CW + 1)'(j_ff) < (CW + 1)'(n_dim))))
      else $error("element index beyond matrix size");

   a_inner_in_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == gemm_ta_pkg::STEP_ACC) |-> ((CW + 1)'(k_ff) < (CW + 1)'(k_dim)))
      else $error("inner index beyond inner length");

endmodule

`default_nettype wire
